// File: hw/rtl/circular_byte_deque_top_defines.svh
// ----------------------------------------------------------------------------
// circular_byte_deque_top_defines.svh
// Assertion macros for the byte deque.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_BYTE_DEQUE_TOP_DEFINES_SVH
`define CIRCULAR_BYTE_DEQUE_TOP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define CBD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define CBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

// File: hw/rtl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types and request codes for the byte deque.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbd_pkg;

    localparam int BYTE_W = 8;
    localparam int REQ_W  = 3;

    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_FROM_LEFT  = 2'd1,
        CELL_FROM_RIGHT = 2'd2,
        CELL_LOAD       = 2'd3
    } cell_op_t;

    typedef struct packed {
        logic     en;
        cell_op_t op;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/cbd_cell.sv
// ----------------------------------------------------------------------------
// cbd_cell
// One storage cell of the deque chain: holds a byte, shifts or loads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbd_cell
(
    input  logic                       clk,
    input  cbd_pkg::cell_ctrl_t        ctrl,
    input  logic [cbd_pkg::BYTE_W-1:0] left_byte,
    input  logic [cbd_pkg::BYTE_W-1:0] right_byte,
    input  logic [cbd_pkg::BYTE_W-1:0] push_byte,
    output logic [cbd_pkg::BYTE_W-1:0] data
);

    logic [cbd_pkg::BYTE_W-1:0] data_reg;
    logic [cbd_pkg::BYTE_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.en)
        begin
            case (ctrl.op)
                cbd_pkg::CELL_FROM_LEFT:  data_next = left_byte;
                cbd_pkg::CELL_FROM_RIGHT: data_next = right_byte;
                cbd_pkg::CELL_LOAD:       data_next = push_byte;
                default:                  data_next = data_reg;
            endcase
        end
    end

    // payload only: no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: hw/rtl/circular_byte_deque_top.sv
// ----------------------------------------------------------------------------
// circular_byte_deque_top
// Fixed-capacity byte deque built as a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | sink      | in_valid/in_stall  | req_type, push_byte
//  out     | source    | out_valid/out_stall| ok, popped_byte, head_byte,
//          |           |                    | tail_byte, fill_level,
//          |           |                    | is_empty, is_full
//
//  One request per cycle when not stalled; each result comes the cycle after.
//  The cell row and the element count update together in the same cycle.
//  Reset empties the deque at once; cell contents are left as they are.
//  A stalled result beat holds in the output register and stalls the input
//  side only while it is still waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "circular_byte_deque_top_defines.svh"

module circular_byte_deque_top
#(
    parameter  int CAPACITY = 16,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [cbd_pkg::REQ_W-1:0]   req_type,
    input  logic [cbd_pkg::BYTE_W-1:0]  push_byte,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        ok,
    output logic [cbd_pkg::BYTE_W-1:0]  popped_byte,
    output logic [cbd_pkg::BYTE_W-1:0]  head_byte,
    output logic [cbd_pkg::BYTE_W-1:0]  tail_byte,
    output logic [CNT_W-1:0]            fill_level,
    output logic                        is_empty,
    output logic                        is_full
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_CNT = CNT_W'(2);

    // The front element always sits in cell 0; the back one in cell count-1.
    logic [cbd_pkg::BYTE_W-1:0] cell_data [CAPACITY];
    cbd_pkg::cell_ctrl_t        cell_ctrl [CAPACITY];

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       ok_reg;
    logic [cbd_pkg::BYTE_W-1:0] popped_reg;
    logic [cbd_pkg::BYTE_W-1:0] head_reg;
    logic [cbd_pkg::BYTE_W-1:0] tail_reg;
    logic [CNT_W-1:0]           fill_reg;
    logic                       empty_reg;
    logic                       full_reg;

    logic accept;

    // request evaluation
    logic                       not_full;
    logic                       not_empty;
    logic                       more_than_one;
    logic [CNT_W-1:0]           last_pos;
    logic [CNT_W-1:0]           prev_pos;
    logic [cbd_pkg::BYTE_W-1:0] last_byte;
    logic [cbd_pkg::BYTE_W-1:0] prev_byte;
    logic                       ok_c;
    logic [cbd_pkg::BYTE_W-1:0] popped_c;
    logic [cbd_pkg::BYTE_W-1:0] head_c;
    logic [cbd_pkg::BYTE_W-1:0] tail_c;
    logic [CNT_W-1:0]           cnt_c;
    cbd_pkg::cell_op_t          row_op;
    logic                       load_back;

    // Take a beat whenever the output register is free or being drained.
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    assign not_full      = (count_reg != CAP_CNT);
    assign not_empty     = (count_reg != '0);
    assign more_than_one = (count_reg > ONE_CNT);
    assign last_pos      = count_reg - ONE_CNT;
    assign prev_pos      = count_reg - TWO_CNT;
    // Read the back and the one before it; junk when the deque is too short,
    // and then masked below.
    assign last_byte     = cell_data[last_pos[IDX_W-1:0]];
    assign prev_byte     = cell_data[prev_pos[IDX_W-1:0]];

    always_comb
    begin
        ok_c      = 1'b0;
        popped_c  = '0;
        head_c    = not_empty ? cell_data[0] : '0;
        tail_c    = not_empty ? last_byte : '0;
        cnt_c     = count_reg;
        row_op    = cbd_pkg::CELL_HOLD;
        load_back = 1'b0;
        case (req_type)
            cbd_pkg::REQ_PUSH_BACK:
            begin
                if (not_full)
                begin
                    // drop the byte into the first free cell
                    ok_c      = 1'b1;
                    load_back = 1'b1;
                    cnt_c     = count_reg + ONE_CNT;
                    head_c    = not_empty ? cell_data[0] : push_byte;
                    tail_c    = push_byte;
                end
            end
            cbd_pkg::REQ_PUSH_FRONT:
            begin
                if (not_full)
                begin
                    // advance the whole row one cell to the right
                    ok_c   = 1'b1;
                    row_op = cbd_pkg::CELL_FROM_LEFT;
                    cnt_c  = count_reg + ONE_CNT;
                    head_c = push_byte;
                    tail_c = not_empty ? last_byte : push_byte;
                end
            end
            cbd_pkg::REQ_POP_BACK:
            begin
                if (not_empty)
                begin
                    ok_c     = 1'b1;
                    popped_c = last_byte;
                    cnt_c    = last_pos;
                    head_c   = more_than_one ? cell_data[0] : '0;
                    tail_c   = more_than_one ? prev_byte : '0;
                end
            end
            cbd_pkg::REQ_POP_FRONT:
            begin
                if (not_empty)
                begin
                    // advance the whole row one cell to the left
                    ok_c     = 1'b1;
                    row_op   = cbd_pkg::CELL_FROM_RIGHT;
                    popped_c = cell_data[0];
                    cnt_c    = last_pos;
                    head_c   = more_than_one ? cell_data[1] : '0;
                    tail_c   = more_than_one ? last_byte : '0;
                end
            end
            cbd_pkg::REQ_CLEAR:
            begin
                ok_c   = 1'b1;
                cnt_c  = '0;
                head_c = '0;
                tail_c = '0;
            end
            default:
            begin
                ok_c = 1'b0;
            end
        endcase
    end

    // the cell row
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [cbd_pkg::BYTE_W-1:0] left_b;
            logic [cbd_pkg::BYTE_W-1:0] right_b;

            if (gi == 0)
            begin : g_first
                assign left_b = push_byte;
            end
            else
            begin : g_inner_left
                assign left_b = cell_data[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_b = '0;
            end
            else
            begin : g_inner_right
                assign right_b = cell_data[gi+1];
            end

            always_comb
            begin
                cell_ctrl[gi].en = accept;
                if (load_back && (count_reg == CNT_W'(gi)))
                begin
                    cell_ctrl[gi].op = cbd_pkg::CELL_LOAD;
                end
                else
                begin
                    cell_ctrl[gi].op = row_op;
                end
            end

            cbd_cell u_cell
            (
                .clk        (clk),
                .ctrl       (cell_ctrl[gi]),
                .left_byte  (left_b),
                .right_byte (right_b),
                .push_byte  (push_byte),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    assign count_next     = accept ? cnt_c : count_reg;
    assign out_valid_next = accept | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result beat; hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg     <= ok_c;
            popped_reg <= popped_c;
            head_reg   <= head_c;
            tail_reg   <= tail_c;
            fill_reg   <= cnt_c;
            empty_reg  <= (cnt_c == '0);
            full_reg   <= (cnt_c == CAP_CNT);
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign popped_byte = popped_reg;
    assign head_byte   = head_reg;
    assign tail_byte   = tail_reg;
    assign fill_level  = fill_reg;
    assign is_empty    = empty_reg;
    assign is_full     = full_reg;

    // checks
    `CBD_ASSERT_SAME(a_count_in_range, 1'b1, count_reg <= CAP_CNT)
    `CBD_ASSERT_NEXT(a_count_holds_idle, !accept, $stable(count_reg))
    `CBD_ASSERT_NEXT(a_push_full_refused,
        accept && !not_full && (req_type == cbd_pkg::REQ_PUSH_BACK ||
        req_type == cbd_pkg::REQ_PUSH_FRONT), !ok_reg && $stable(count_reg))
    `CBD_ASSERT_NEXT(a_clear_empties,
        accept && (req_type == cbd_pkg::REQ_CLEAR),
        count_reg == '0 && empty_reg && ok_reg)

endmodule

// File: bench/circular_byte_deque_top_tb.sv
// ----------------------------------------------------------------------------
// circular_byte_deque_top_tb
// Self-checking bench for the byte deque: a scoreboard class mirrors the
// deque's contents and indices, predicts the status beat for every request
// beat and checks each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circular_byte_deque_top_tb;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic [cbd_pkg::REQ_W-1:0]  req_t;
    typedef logic [cbd_pkg::BYTE_W-1:0] data_t;

    // Request codes above clear do nothing in the block.
    localparam req_t REQ_CODE_MAX = '1;

    localparam int PHASE_ITEMS = 257;
    localparam int BURST_LEN   = 40;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic             ok;
        data_t            popped_byte;
        data_t            head_byte;
        data_t            tail_byte;
        logic [CNT_W-1:0] fill_level;
        logic             is_empty;
        logic             is_full;
    } deque_status_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the ring, its indices and its count, plus the
    // queue of status beats still owed by the block.
    // ------------------------------------------------------------------------
    class deque_scoreboard;
        data_t         slots [DEPTH];
        int            head_idx;
        int            tail_idx;
        int            count;
        deque_status_t owed_status [$];
        int            mismatches;

        function new();
            foreach (slots[i])
                slots[i] = '0;
            head_idx   = 0;
            tail_idx   = 0;
            count      = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return owed_status.size();
        endfunction

        // Apply one accepted request to the ring and queue the status it yields.
        function void note_request(req_t req, data_t data);
            deque_status_t s;
            s = '0;
            case (req)
                cbd_pkg::REQ_PUSH_BACK:
                    if (count < DEPTH)
                    begin
                        slots[tail_idx] = data;
                        tail_idx        = (tail_idx + 1) % DEPTH;
                        count++;
                        s.ok = 1'b1;
                    end
                cbd_pkg::REQ_PUSH_FRONT:
                    if (count < DEPTH)
                    begin
                        head_idx        = (head_idx + DEPTH - 1) % DEPTH;
                        slots[head_idx] = data;
                        count++;
                        s.ok = 1'b1;
                    end
                cbd_pkg::REQ_POP_BACK:
                    if (count > 0)
                    begin
                        tail_idx      = (tail_idx + DEPTH - 1) % DEPTH;
                        s.popped_byte = slots[tail_idx];
                        count--;
                        s.ok = 1'b1;
                    end
                cbd_pkg::REQ_POP_FRONT:
                    if (count > 0)
                    begin
                        s.popped_byte = slots[head_idx];
                        head_idx      = (head_idx + 1) % DEPTH;
                        count--;
                        s.ok = 1'b1;
                    end
                cbd_pkg::REQ_CLEAR:
                begin
                    head_idx = 0;
                    tail_idx = 0;
                    count    = 0;
                    s.ok     = 1'b1;
                end
                default: ;
            endcase
            if (count > 0)
            begin
                s.head_byte = slots[head_idx];
                s.tail_byte = slots[(tail_idx + DEPTH - 1) % DEPTH];
            end
            s.fill_level = count[CNT_W-1:0];
            s.is_empty   = (count == 0);
            s.is_full    = (count == DEPTH);
            owed_status.push_back(s);
        endfunction

        function void report(string what, deque_status_t exp, deque_status_t got);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("[%0t] %s: exp ok=%b pop=%h head=%h tail=%h fill=%0d e=%b f=%b",
                         $realtime, what, exp.ok, exp.popped_byte, exp.head_byte,
                         exp.tail_byte, exp.fill_level, exp.is_empty, exp.is_full,
                         "\n    got ok=%b pop=%h head=%h tail=%h fill=%0d e=%b f=%b",
                         got.ok, got.popped_byte, got.head_byte, got.tail_byte,
                         got.fill_level, got.is_empty, got.is_full);
        endfunction

        function void check_result(deque_status_t got);
            deque_status_t exp;
            if (owed_status.size() == 0)
            begin
                report("unexpected status beat", '0, got);
                return;
            end
            exp = owed_status.pop_front();
            if (got.ok !== exp.ok || got.popped_byte !== exp.popped_byte
                || got.head_byte !== exp.head_byte || got.tail_byte !== exp.tail_byte
                || got.fill_level !== exp.fill_level || got.is_empty !== exp.is_empty
                || got.is_full !== exp.is_full)
                report("status mismatch", exp, got);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input is known from time zero.
    // ------------------------------------------------------------------------
    logic             clk;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    req_t             req_type  = '0;
    data_t            push_byte = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             ok;
    data_t            popped_byte;
    data_t            head_byte;
    data_t            tail_byte;
    logic [CNT_W-1:0] fill_level;
    logic             is_empty;
    logic             is_full;

    // Percentages of cycles in which the sender idles / the receiver stalls.
    int idle_pct  = 0;
    int stall_pct = 0;

    deque_scoreboard sb = new();

    circular_byte_deque_top #(
        .CAPACITY (DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .push_byte   (push_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .popped_byte (popped_byte),
        .head_byte   (head_byte),
        .tail_byte   (tail_byte),
        .fill_level  (fill_level),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit: far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Receiver: decide at each falling edge whether to stall the next beat.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Monitor: both channels are sampled at the rising edge, before the block's
    // registers move. Note the request beat first, then check the status beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(req_type, push_byte);
            if (out_valid && !out_stall)
                sb.check_result('{ok, popped_byte, head_byte, tail_byte,
                                  fill_level, is_empty, is_full});
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Entered and left at a falling edge; valid is assigned at most
    // once per edge, so a back-to-back beat keeps valid high throughout.
    // ------------------------------------------------------------------------
    task automatic send_request(req_t req, data_t data);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        push_byte <= data;
        // Hold the beat until the block takes it.
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold off the sender until every owed status beat has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Mostly well-formed traffic; the push share steers the fill level so
    // that bursts run the deque up to full and down to empty.
    function automatic req_t pick_request(int push_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < 1)
            return cbd_pkg::REQ_CLEAR;
        if (roll < 4)
            return req_t'($urandom_range(REQ_CODE_MAX, cbd_pkg::REQ_CLEAR + 1));
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? cbd_pkg::REQ_PUSH_BACK : cbd_pkg::REQ_PUSH_FRONT;
        return $urandom_range(1) ? cbd_pkg::REQ_POP_BACK : cbd_pkg::REQ_POP_FRONT;
    endfunction

    task automatic run_random(int n_items);
        int push_pct;
        for (int i = 0; i < n_items; i++)
        begin
            // Pick a fresh bias at the start of each burst.
            if (i % BURST_LEN == 0)
                case ($urandom_range(2))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    default: push_pct = 50;
                endcase
            send_request(pick_request(push_pct), data_t'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: refused pops on the empty deque and the unused codes.
        send_request(cbd_pkg::REQ_POP_BACK, 8'hFF);
        send_request(cbd_pkg::REQ_POP_FRONT, 8'hFF);
        for (int c = cbd_pkg::REQ_CLEAR + 1; c <= REQ_CODE_MAX; c++)
            send_request(c[cbd_pkg::REQ_W-1:0], 8'h5A);

        // Push front from index zero to force the wrap, then fill to the brim.
        send_request(cbd_pkg::REQ_PUSH_BACK, 8'h00);
        send_request(cbd_pkg::REQ_PUSH_FRONT, 8'hFF);
        for (int k = 2; k < DEPTH; k++)
            send_request((k % 2) ? cbd_pkg::REQ_PUSH_FRONT : cbd_pkg::REQ_PUSH_BACK,
                         (k % 2) ? 8'hAA : 8'h55);

        // Refused pushes on the full deque, then pops from both ends.
        send_request(cbd_pkg::REQ_PUSH_BACK, 8'h11);
        send_request(cbd_pkg::REQ_PUSH_FRONT, 8'h22);
        send_request(cbd_pkg::REQ_POP_BACK, 8'h00);
        send_request(cbd_pkg::REQ_POP_FRONT, 8'h00);

        // Clear, then a pop that must be refused again.
        send_request(cbd_pkg::REQ_CLEAR, 8'hFF);
        send_request(cbd_pkg::REQ_POP_FRONT, 8'h00);
        drain_results();

        // Random phases: free flow, idle sender, stalling receiver, both.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 75; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            run_random(PHASE_ITEMS);
            drain_results();
        end

        // Let any stray beat arrive; one still owed counts as a mismatch.
        stall_pct = 0;
        repeat (8) @(negedge clk);
        if (sb.pending() != 0)
            sb.mismatches++;

        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
